// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned PrioWidth = 16;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // One stored entry of the sorted chain.
  typedef struct packed {
    logic signed [PrioWidth-1:0] prio;
    logic        [DataWidth-1:0] data;
  } entry_t;

  // Broadcast control that every cell sees in the same cycle.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One cell of the sorted chain: holds a single entry and trades with its neighbors.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     new_entry_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  logic                left_le_i,
  input  spq_pkg::entry_t     right_entry_i,
  input  logic                occupied_i,
  output spq_pkg::entry_t     entry_o,
  output logic                le_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // The held entry stays ahead of the new one when its priority is not larger.
  assign le_o = occupied_i && ($signed(entry_q.prio) <= $signed(new_entry_i.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!le_o) begin
        entry_d = left_le_i ? new_entry_i : left_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/stable_priority_queue_unit.sv =====
// Top level of the stable min-priority queue built as a chain of sorted cells.
//
// The input channel carries one transaction per item: opcode_i selects an
// insert of (priority_req_i, payload_i) or a remove of the head entry. The
// output channel returns one transaction per input item with the head entry,
// the empty and full flags, the entry count and the rejected flag, all as they
// stand after the item took effect.
//
// The queue lives in a row of identical cells kept sorted by signed priority,
// ties in insertion order. Every cell compares its entry with the incoming one
// in parallel, so an insert or a remove updates every cell together: each
// cell keeps its entry, takes the new entry, or takes its neighbor's entry.
// Output valid rises in the cycle after input acceptance, and one item is
// taken per cycle as long as the output side is not stalled.
//
// The result sits in an output register. While that register is full and the
// receiver stalls, in_stall_o is raised and no new item is taken; the result
// holds steady until it is accepted.
//
// Reset clears the entry count and the output valid flag. Cell contents are
// not reset; a cell is only read once an insert has written it.
module stable_priority_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [spq_pkg::PrioWidth-1:0] priority_req_i,
  input  logic        [spq_pkg::DataWidth-1:0] payload_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [spq_pkg::DataWidth-1:0] head_payload_o,
  output logic signed [spq_pkg::PrioWidth-1:0] head_priority_o,
  output logic                                is_empty_o,
  output logic                                is_full_o,
  output logic                                rejected_o,
  output logic        [spq_pkg::CntWidth-1:0]  entry_count_o
);

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CntWidth;

  logic                   accept;
  logic                   is_insert;
  logic                   is_remove;
  logic                   full_now;
  logic                   empty_now;
  logic                   reject_d;
  spq_pkg::cell_ctrl_t    ctrl;
  spq_pkg::entry_t        new_entry;
  spq_pkg::entry_t        cell_entry [Depth];
  logic [Depth-1:0]       cell_le;
  logic [Depth-1:0]       occupied;

  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q;
  spq_pkg::entry_t        head_q, head_d;
  logic                   empty_q, full_q, reject_q;
  logic [CntW-1:0]        out_count_q;

  // A new transaction is taken unless the held result is still waiting.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_insert = (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_INSERT);
  assign is_remove = (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_REMOVE);
  assign full_now  = (count_q == CntW'(Depth));
  assign empty_now = (count_q == '0);

  // A full queue drops inserts; an empty queue ignores removes.
  assign ctrl.insert = accept && is_insert && !full_now;
  assign ctrl.remove = accept && is_remove && !empty_now;
  assign reject_d    = is_insert && full_now;

  assign new_entry.prio = priority_req_i;
  assign new_entry.data = payload_i;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_le;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      // The head cell has nothing ahead of it, so it takes the new entry directly.
      assign left_entry = new_entry;
      assign left_le    = 1'b1;
    end else begin : g_rest
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .left_le_i     (left_le),
      .right_entry_i (right_entry),
      .occupied_i    (occupied[i]),
      .entry_o       (cell_entry[i]),
      .le_o          (cell_le[i])
    );
  end

  // Next entry count.
  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Head after this transaction, taken from the same decisions the cells make.
  always_comb begin
    head_d = '0;
    if (ctrl.insert) begin
      head_d = cell_le[0] ? cell_entry[0] : new_entry;
    end else if (ctrl.remove) begin
      if (count_q > CntW'(1)) begin
        head_d = cell_entry[1];
      end
    end else if (!empty_now) begin
      head_d = cell_entry[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register; loaded only when a transaction is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q      <= head_d;
      empty_q     <= (count_d == '0);
      full_q      <= (count_d == CntW'(Depth));
      reject_q    <= reject_d;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign head_payload_o  = head_q.data;
  assign head_priority_o = head_q.prio;
  assign is_empty_o      = empty_q;
  assign is_full_o       = full_q;
  assign rejected_o      = reject_q;
  assign entry_count_o   = out_count_q;

  // The entry count never exceeds the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds depth");

  // A rejected insert is only reported against a full queue.
  a_reject_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> is_full_o)
    else $error("rejected reported while not full");

  // An empty queue reports a zero head.
  a_empty_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (head_payload_o == '0 && head_priority_o == '0))
    else $error("empty queue reports a nonzero head");

  // A remove from a non-empty queue lowers the count by one.
  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not lower the entry count");

endmodule
